// ===== rtl/q4_fractal_embedding_dequant_core_assert.svh =====
// assertion helpers for the q4 embedding dequantizer
`ifndef Q4_FRACTAL_EMBEDDING_DEQUANT_CORE_ASSERT_SVH
`define Q4_FRACTAL_EMBEDDING_DEQUANT_CORE_ASSERT_SVH

// clocked check, off during reset
`define Q4FED_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// condition in one cycle implies result in the next
`define Q4FED_ASSERT_NEXT(lbl, ante, cons, msg) \
   `Q4FED_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

// ===== rtl/q4fed_pkg.sv =====
// ----------------------------------------------------------------------------
// q4fed_pkg
// types, codes and the fp16 scale multiply of the q4 embedding dequantizer
// ----------------------------------------------------------------------------
`default_nettype none

package q4fed_pkg;

   localparam int GROUP_ELEMS = 32;
   localparam int CALC_W      = 32;

   localparam logic        CMD_WRITE   = 1'b0;
   localparam logic        CMD_DEQUANT = 1'b1;

   localparam logic        CSR_ROW_COUNT   = 1'b0;
   localparam logic        CSR_HIDDEN_SIZE = 1'b1;

   localparam logic [2:0]  ST_OK        = 3'd0;
   localparam logic [2:0]  ST_BAD_SHAPE = 3'd1;
   localparam logic [2:0]  ST_BAD_ROW   = 3'd2;
   localparam logic [2:0]  ST_BAD_GROUP = 3'd3;
   localparam logic [2:0]  ST_TOO_BIG   = 3'd4;

   localparam logic [14:0] HALF_INF  = 15'h7C00;
   localparam logic [14:0] HALF_QNAN = 15'h7E00;

   typedef struct packed {
      logic        command;
      logic [19:0] byte_address;
      logic [7:0]  byte_data;
      logic [11:0] row_index;
      logic [8:0]  group_index;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [13:0] element_index;
      logic [15:0] value_half;
      logic        last;
   } rsp_type;

   // signed nibble times fp16 scale, round to nearest even
   function automatic logic [15:0] half_mul(input logic [3:0] nib, input logic [15:0] s);
      logic              sgn;
      logic [3:0]        av;
      logic [4:0]        es;
      logic [9:0]        man;
      logic [10:0]       sm;
      logic signed [7:0] e;
      logic signed [7:0] ex;
      logic [7:0]        sa;
      logic [13:0]       p;
      logic [3:0]        b;
      logic [3:0]        sh;
      logic [13:0]       rem;
      logic [13:0]       halfv;
      logic [11:0]       m;
      logic [15:0]       r;
      sgn   = nib[3] ^ s[15];
      av    = nib[3] ? 4'(~nib + 4'd1) : nib;
      es    = s[14:10];
      man   = s[9:0];
      sm    = (es == 5'd0) ? {1'b0, man} : {1'b1, man};
      e     = (es == 5'd0) ? -8'sd24 : $signed({3'b0, es}) - 8'sd25;
      p     = 14'(av) * 14'(sm);
      b     = 4'd0;
      for (int i = 0; i < 14; i++) begin
         if (p[i]) begin
            b = 4'(i);
         end
      end
      ex    = $signed({4'b0, b}) + e;
      sa    = 8'(e + 8'sd24);
      sh    = 4'd0;
      rem   = 14'd0;
      halfv = 14'd0;
      m     = 12'd0;
      r     = {sgn, 15'd0};
      if (es == 5'h1F) begin
         r = (man != 10'd0 || av == 4'd0) ? {sgn, HALF_QNAN} : {sgn, HALF_INF};
      end else if (av == 4'd0 || sm == 11'd0) begin
         r = {sgn, 15'd0};
      end else if (ex < -8'sd14) begin
         r = {sgn, 15'({1'b0, p} << sa)};
      end else begin
         if (b > 4'd10) begin
            sh    = b - 4'd10;
            rem   = p & ((14'd1 << sh) - 14'd1);
            halfv = 14'd1 << (sh - 4'd1);
            m     = 12'(p >> sh);
            if (rem > halfv || (rem == halfv && m[0])) begin
               m = m + 12'd1;
            end
            if (m == 12'd2048) begin
               m  = 12'd1024;
               ex = ex + 8'sd1;
            end
         end else begin
            m = 12'(p << (4'd10 - b));
         end
         if (ex > 8'sd15) begin
            r = {sgn, HALF_INF};
         end else begin
            r = {sgn, 5'(ex + 8'sd15), m[9:0]};
         end
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/q4_fractal_embedding_dequant_core.sv =====
// ----------------------------------------------------------------------------
// q4_fractal_embedding_dequant_core
// A byte memory holds a 4-bit embedding table in 64x1024 fractal cells with
// per-group fp16 scales. A write request stores one byte. A dequantize
// request checks the shape, then works out the cell and scale addresses on
// one shared multiplier and fetches the two scale bytes through the single
// read port, then streams 32 fp16 results, one per cycle while the output is
// not stalled. Bad shape, row, group or table size answers with one error
// result. A new request is taken once the previous one has handed its last
// result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module q4_fractal_embedding_dequant_core #(
   parameter int MEM_BYTES  = 1048576,
   parameter int MAX_ROWS   = 4096,
   parameter int MAX_HIDDEN = 16384
) (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_valid,
   output logic                   req_stall,
   input  q4fed_pkg::req_type     req_payload,
   output logic                   rsp_valid,
   input  wire                    rsp_stall,
   output q4fed_pkg::rsp_type     rsp_payload,
   input  wire                    csr_wr_en,
   input  wire  [0:0]             csr_index,
   input  wire  [14:0]            csr_data
);

   `include "q4_fractal_embedding_dequant_core_assert.svh"

   localparam int AW = $clog2(MEM_BYTES);
   localparam int CW = q4fed_pkg::CALC_W;

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_SIZE  = 4'd1;
   localparam logic [3:0] S_CHECK = 4'd2;
   localparam logic [3:0] S_M1    = 4'd3;
   localparam logic [3:0] S_M2    = 4'd4;
   localparam logic [3:0] S_M3    = 4'd5;
   localparam logic [3:0] S_M4    = 4'd6;
   localparam logic [3:0] S_M5    = 4'd7;
   localparam logic [3:0] S_SC0   = 4'd8;
   localparam logic [3:0] S_SC1   = 4'd9;
   localparam logic [3:0] S_SC2   = 4'd10;
   localparam logic [3:0] S_LANE  = 4'd11;
   localparam logic [3:0] S_ERR   = 4'd12;

   localparam logic [4:0] LAST_LANE = 5'(q4fed_pkg::GROUP_ELEMS - 1);

   logic [3:0]          state_ff;
   logic [3:0]          state_in;
   logic [12:0]         row_count_ff;
   logic [14:0]         hidden_ff;
   logic [11:0]         n_ff;
   logic [8:0]          g_ff;
   logic [6:0]          nc_ff;
   logic [10:0]         kc_ff;
   logic [CW-1:0]       prod_ff;
   logic [CW-1:0]       cell_ff;
   logic [CW-1:0]       soff_ff;
   logic [2:0]          err_ff;
   logic [7:0]          scale_lo_ff;
   logic [15:0]         scale_ff;
   logic [4:0]          lane_ff;
   logic [7:0]          rd_ff;
   logic [7:0]          mem [MEM_BYTES];
   logic                rsp_valid_ff;
   q4fed_pkg::rsp_type  rsp_payload_ff;

   logic                req_accept;
   logic                fire;
   logic [15:0]         mul_a;
   logic [15:0]         mul_b;
   logic [CW-1:0]       mul_q;
   logic [12:0]         n0;
   logic [12:0]         r_rem;
   logic [14:0]         k0;
   logic [14:0]         h_rem;
   logic [4:0]          lane_sel;
   logic [8:0]          fr;
   logic [6:0]          pi;
   logic [6:0]          ph;
   logic [CW-1:0]       lane_addr;
   logic [CW-1:0]       rd_addr;
   logic [3:0]          nib;
   logic [2:0]          chk;
   logic [CW-1:0]       size_bytes;

   assign req_stall   = (state_ff != S_IDLE);
   assign req_accept  = req_valid && !req_stall;
   assign fire        = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   assign n0    = {1'b0, n_ff[11:6], 6'b0};
   assign r_rem = row_count_ff - n0;
   assign k0    = {1'b0, g_ff[8:5], 10'b0};
   assign h_rem = hidden_ff - k0;
   assign size_bytes = (prod_ff << 4) + (prod_ff << 1);

   always_comb begin
      unique case (state_ff)
         S_SIZE:  begin mul_a = 16'(row_count_ff);  mul_b = 16'(hidden_ff[14:5]); end
         S_M1:    begin mul_a = 16'(n0);            mul_b = 16'(hidden_ff[14:1]); end
         S_M2:    begin mul_a = 16'(nc_ff);         mul_b = 16'(k0[14:1]);        end
         S_M3:    begin mul_a = 16'(n0);            mul_b = 16'(hidden_ff[14:4]); end
         S_M4:    begin mul_a = 16'(nc_ff);         mul_b = 16'(k0[14:4]);        end
         S_M5:    begin mul_a = 16'(n_ff[5:0]);     mul_b = 16'(kc_ff[10:4]);     end
         default: begin mul_a = 16'd0;              mul_b = 16'd0;                end
      endcase
      mul_q = CW'(mul_a) * CW'(mul_b);
   end

   always_comb begin
      priority if (row_count_ff == 13'd0 || hidden_ff == 15'd0 || row_count_ff[3:0] != 4'd0 ||
                   hidden_ff[4:0] != 5'd0 || CW'(row_count_ff) > CW'(MAX_ROWS) ||
                   CW'(hidden_ff) > CW'(MAX_HIDDEN)) begin
         chk = q4fed_pkg::ST_BAD_SHAPE;
      end else if ({1'b0, n_ff} >= row_count_ff) begin
         chk = q4fed_pkg::ST_BAD_ROW;
      end else if ({1'b0, g_ff} >= hidden_ff[14:5]) begin
         chk = q4fed_pkg::ST_BAD_GROUP;
      end else if (size_bytes > CW'(MEM_BYTES)) begin
         chk = q4fed_pkg::ST_TOO_BIG;
      end else begin
         chk = q4fed_pkg::ST_OK;
      end
   end

   always_comb begin
      lane_sel  = (state_ff == S_LANE && fire) ? lane_ff + 5'd1 : lane_ff;
      fr        = 9'({g_ff[4:0], lane_sel[4]} * nc_ff[6:4]) + 9'(n_ff[5:4]);
      pi        = {n_ff[3:0], lane_sel[3:1]};
      ph        = {pi[4:0], pi[6:5]};
      lane_addr = cell_ff + CW'({fr, 7'b0}) + CW'(ph);
      unique case (state_ff)
         S_SC0:   rd_addr = soff_ff;
         S_SC1:   rd_addr = soff_ff + CW'(1);
         default: rd_addr = lane_addr;
      endcase
      nib = lane_ff[0] ? rd_ff[7:4] : rd_ff[3:0];
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:  if (req_accept && req_payload.command == q4fed_pkg::CMD_DEQUANT) begin
            state_in = S_SIZE;
         end
         S_SIZE:  state_in = S_CHECK;
         S_CHECK: state_in = (chk == q4fed_pkg::ST_OK) ? S_M1 : S_ERR;
         S_M1:    state_in = S_M2;
         S_M2:    state_in = S_M3;
         S_M3:    state_in = S_M4;
         S_M4:    state_in = S_M5;
         S_M5:    state_in = S_SC0;
         S_SC0:   state_in = S_SC1;
         S_SC1:   state_in = S_SC2;
         S_SC2:   state_in = S_LANE;
         S_LANE:  if (fire && lane_ff == LAST_LANE) begin
            state_in = S_IDLE;
         end
         S_ERR:   if (fire) begin
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // blob memory
   always_ff @(posedge clock) begin
      if (req_accept && req_payload.command == q4fed_pkg::CMD_WRITE &&
          CW'(req_payload.byte_address) < CW'(MEM_BYTES)) begin
         mem[AW'(CW'(req_payload.byte_address))] <= req_payload.byte_data;
      end
      rd_ff <= mem[rd_addr[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         row_count_ff <= 13'd0;
         hidden_ff    <= 15'd0;
         rsp_valid_ff <= 1'b0;
         lane_ff      <= 5'd0;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) begin
            if (csr_index == q4fed_pkg::CSR_ROW_COUNT) begin
               row_count_ff <= csr_data[12:0];
            end else begin
               hidden_ff <= csr_data;
            end
         end
         if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (state_ff == S_SC1) begin
            lane_ff <= 5'd0;
         end
         if (state_ff == S_LANE && fire) begin
            rsp_valid_ff <= 1'b1;
            lane_ff      <= lane_ff + 5'd1;
         end
         if (state_ff == S_ERR && fire) begin
            rsp_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         n_ff <= req_payload.row_index;
         g_ff <= req_payload.group_index;
      end
      unique case (state_ff)
         S_SIZE: begin
            prod_ff <= mul_q;
            nc_ff   <= (r_rem < 13'd64) ? r_rem[6:0] : 7'd64;
            kc_ff   <= (h_rem < 15'd1024) ? h_rem[10:0] : 11'd1024;
         end
         S_CHECK: err_ff  <= chk;
         S_M1:    cell_ff <= mul_q;
         S_M2:    cell_ff <= cell_ff + mul_q;
         S_M3:    soff_ff <= (prod_ff << 4) + CW'({g_ff[4:0], 1'b0}) + mul_q;
         S_M4:    soff_ff <= soff_ff + mul_q;
         S_M5:    soff_ff <= soff_ff + mul_q;
         S_SC1:   scale_lo_ff <= rd_ff;
         S_SC2:   scale_ff <= {rd_ff, scale_lo_ff};
         S_LANE: if (fire) begin
            rsp_payload_ff.status        <= q4fed_pkg::ST_OK;
            rsp_payload_ff.element_index <= {g_ff, lane_ff};
            rsp_payload_ff.value_half    <= q4fed_pkg::half_mul(nib, scale_ff);
            rsp_payload_ff.last          <= (lane_ff == LAST_LANE);
         end
         S_ERR: if (fire) begin
            rsp_payload_ff.status        <= err_ff;
            rsp_payload_ff.element_index <= 14'd0;
            rsp_payload_ff.value_half    <= 16'd0;
            rsp_payload_ff.last          <= 1'b1;
         end
         default: begin
         end
      endcase
   end

   `Q4FED_ASSERT_NEXT(a_last_lane_done, state_ff == S_LANE && fire && lane_ff == LAST_LANE, state_ff == S_IDLE && rsp_valid_ff && rsp_payload_ff.last, "last lane did not end the request")
   `Q4FED_ASSERT(a_lane_start, state_ff == S_SC2 |-> lane_ff == 5'd0, "lane counter not cleared before streaming")
   `Q4FED_ASSERT(a_mid_group, rsp_valid_ff && !rsp_payload_ff.last |-> state_ff == S_LANE, "partial group result outside streaming")

endmodule

`default_nettype wire

// ===== tb/q4_fractal_embedding_dequant_core_test.sv =====
// ----------------------------------------------------------------------------
// q4_fractal_embedding_dequant_core_test
// Loads table bytes and asks for dequantized groups under a range of table
// shapes, with random idling on both channels and one long output hold. Every
// result is checked against a model of the table layout and the fp16 scaling.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module q4_fractal_embedding_dequant_core_test;

   localparam longint MEM_SIZE   = 1048576;
   localparam int     ROW_LIMIT  = 4096;
   localparam int     COL_LIMIT  = 16384;
   localparam int     CYCLE_CAP  = 500000;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   q4fed_pkg::req_type  req_payload;
   logic                rsp_valid;
   logic                rsp_stall;
   q4fed_pkg::rsp_type  rsp_payload;
   logic                csr_wr_en;
   logic [0:0]          csr_index;
   logic [14:0]         csr_data;

   q4_fractal_embedding_dequant_core dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_payload(rsp_payload),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_data(csr_data)
   );

   q4fed_pkg::req_type  pending_reqs[$];
   q4fed_pkg::rsp_type  expected_rsps[$];
   logic [7:0]  table_bytes[longint];
   bit          loaded_bytes[longint];
   int          loaded_rows[$];
   int          loaded_groups[$];
   logic [12:0] rows_cfg;
   logic [14:0] hidden_cfg;
   int          issued_reqs;
   int          accepted_reqs;
   int          seen_rsps;
   int          group_reads;
   int          errors;
   int          mismatches;
   int          cycles;
   int          hold_left;
   bit          hold_done;
   bit          calm;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // signed nibble times binary16 scale, nearest-even
   function automatic logic [15:0] half_product(logic [3:0] nib, logic [15:0] s);
      logic        sign;
      int          mag;
      int          sig;
      int          pw;
      int          prod;
      int          msb;
      int          ex;
      int          sh;
      int          rem;
      int          halfw;
      int          m;
      sign = nib[3] ^ s[15];
      mag  = nib[3] ? 16 - int'(nib) : int'(nib);
      if (s[14:10] == 5'h1F) begin
         if (s[9:0] != 0 || mag == 0) return {sign, q4fed_pkg::HALF_QNAN};
         return {sign, q4fed_pkg::HALF_INF};
      end
      if (s[14:10] == 0) begin
         sig = int'(s[9:0]);
         pw  = -24;
      end else begin
         sig = int'(s[9:0]) + 1024;
         pw  = int'(s[14:10]) - 25;
      end
      if (mag == 0 || sig == 0) return {sign, 15'd0};
      prod = mag * sig;
      msb  = 0;
      for (int i = 0; i < 15; i++) begin
         if ((prod >> i) != 0) msb = i;
      end
      ex = msb + pw;
      if (ex < -14) return {sign, 15'(prod << (pw + 24))};
      if (msb > 10) begin
         sh    = msb - 10;
         rem   = prod & ((1 << sh) - 1);
         halfw = 1 << (sh - 1);
         m     = prod >> sh;
         if (rem > halfw || (rem == halfw && m[0])) m++;
         if (m == 2048) begin
            m = 1024;
            ex++;
         end
      end else begin
         m = prod << (10 - msb);
      end
      if (ex > 15) return {sign, q4fed_pkg::HALF_INF};
      return {sign, 5'(ex + 15), 10'(m)};
   endfunction

   function automatic logic [2:0] group_status(longint n, longint g);
      longint r;
      longint h;
      r = rows_cfg;
      h = hidden_cfg;
      if (r == 0 || h == 0 || r % 16 != 0 || h % 32 != 0 || r > ROW_LIMIT ||
          h > COL_LIMIT) return q4fed_pkg::ST_BAD_SHAPE;
      if (n >= r) return q4fed_pkg::ST_BAD_ROW;
      if (g >= h / 32) return q4fed_pkg::ST_BAD_GROUP;
      if (r * (h / 32) * 18 > MEM_SIZE) return q4fed_pkg::ST_TOO_BIG;
      return q4fed_pkg::ST_OK;
   endfunction

   function automatic longint nibble_addr(longint n, longint g, longint lane);
      longint h;
      longint n0;
      longint nc;
      longint kb;
      longint k0;
      longint k;
      longint fr;
      longint flat;
      longint pi;
      h    = hidden_cfg;
      n0   = n / 64 * 64;
      nc   = (rows_cfg - n0 < 64) ? rows_cfg - n0 : 64;
      kb   = g * 32;
      k0   = kb / 1024 * 1024;
      k    = kb + lane;
      fr   = ((k - k0) / 16) * (nc / 16) + (n - n0) / 16;
      flat = (n % 16) * 16 + k % 16;
      pi   = flat / 2;
      return n0 * (h / 2) + nc * (k0 / 2) + fr * 128 + 4 * (pi % 32) + pi / 32;
   endfunction

   function automatic longint scale_addr(longint n, longint g);
      longint h;
      longint n0;
      longint nc;
      longint kb;
      longint k0;
      longint kc;
      h  = hidden_cfg;
      n0 = n / 64 * 64;
      nc = (rows_cfg - n0 < 64) ? rows_cfg - n0 : 64;
      kb = g * 32;
      k0 = kb / 1024 * 1024;
      kc = (h - k0 < 1024) ? h - k0 : 1024;
      return rows_cfg * (h / 32) * 16 + n0 * (h / 16) + nc * (k0 / 16) +
             (n - n0) * (kc / 16) + (kb - k0) / 16;
   endfunction

   function automatic logic [7:0] table_read(longint a);
      return table_bytes.exists(a) ? table_bytes[a] : 8'd0;
   endfunction

   task automatic predict_request(q4fed_pkg::req_type r);
      logic [2:0]          st;
      logic [15:0]         scale;
      logic [7:0]          b;
      q4fed_pkg::rsp_type  e;
      longint              n;
      longint              g;
      if (r.command == q4fed_pkg::CMD_WRITE) begin
         table_bytes[longint'(r.byte_address)] = r.byte_data;
         return;
      end
      n  = r.row_index;
      g  = r.group_index;
      st = group_status(n, g);
      if (st != q4fed_pkg::ST_OK) begin
         e = '{status: st, element_index: 14'd0, value_half: 16'd0, last: 1'b1};
         expected_rsps.push_back(e);
         return;
      end
      group_reads++;
      scale = {table_read(scale_addr(n, g) + 1), table_read(scale_addr(n, g))};
      for (int lane = 0; lane < 32; lane++) begin
         b = table_read(nibble_addr(n, g, lane));
         e.status        = q4fed_pkg::ST_OK;
         e.element_index = 14'(g * 32 + lane);
         e.value_half    = half_product(lane[0] ? b[7:4] : b[3:0], scale);
         e.last          = (lane == 31);
         expected_rsps.push_back(e);
      end
   endtask

   function automatic q4fed_pkg::req_type noise_req();
      q4fed_pkg::req_type r;
      r = q4fed_pkg::req_type'(50'({$urandom, $urandom}));
      return r;
   endfunction

   task automatic push_write(longint a, logic [7:0] d);
      q4fed_pkg::req_type r;
      r              = noise_req();
      r.command      = q4fed_pkg::CMD_WRITE;
      r.byte_address = 20'(a);
      r.byte_data    = d;
      pending_reqs.push_back(r);
      loaded_bytes[a] = 1'b1;
      issued_reqs++;
   endtask

   task automatic push_dequant(int n, int g);
      q4fed_pkg::req_type r;
      r             = noise_req();
      r.command     = q4fed_pkg::CMD_DEQUANT;
      r.row_index   = 12'(n);
      r.group_index = 9'(g);
      pending_reqs.push_back(r);
      issued_reqs++;
   endtask

   function automatic logic [7:0] data_byte();
      case ($urandom_range(0, 7))
         0: return 8'h00;
         1: return 8'h88;
         2: return 8'hFF;
         default: return 8'($urandom);
      endcase
   endfunction

   function automatic logic [15:0] scale_pick();
      logic s;
      s = 1'($urandom);
      case ($urandom_range(0, 9))
         0: return {s, q4fed_pkg::HALF_INF};
         1: return {s, 5'h1F, 10'($urandom_range(1, 1023))};
         2: return {s, 15'd0};
         3: return {s, 5'd0, 10'($urandom)};
         4: return {s, 15'h7BFF};
         5: return {s, 15'h0400};
         6: return {s, 5'($urandom_range(17, 30)), 10'($urandom)};
         default: return 16'($urandom);
      endcase
   endfunction

   // writes whatever bytes the group still lacks (all of them if fresh)
   task automatic load_and_read(int n, int g, bit fresh);
      longint      a;
      logic [15:0] sc;
      if (group_status(n, g) == q4fed_pkg::ST_OK) begin
         for (int lane = 0; lane < 32; lane += 2) begin
            a = nibble_addr(n, g, lane);
            if (fresh || !loaded_bytes.exists(a)) push_write(a, data_byte());
         end
         a = scale_addr(n, g);
         if (fresh || !loaded_bytes.exists(a) || !loaded_bytes.exists(a + 1)) begin
            sc = scale_pick();
            push_write(a, sc[7:0]);
            push_write(a + 1, sc[15:8]);
         end
         loaded_rows.push_back(n);
         loaded_groups.push_back(g);
      end
      push_dequant(n, g);
   endtask

   task automatic write_csr(logic [0:0] idx, logic [14:0] value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      if (idx == q4fed_pkg::CSR_ROW_COUNT) rows_cfg = 13'(value);
      else hidden_cfg = value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      #1;
   endtask

   task automatic drain();
      do begin
         @(posedge clock);
         #1;
      end while (pending_reqs.size() != 0 || accepted_reqs != issued_reqs ||
                 expected_rsps.size() != 0);
      repeat (60) @(posedge clock);
      #1;
   endtask

   task automatic random_phase(int rows, int hidden, int budget);
      int start;
      int n;
      int g;
      int pick;
      write_csr(q4fed_pkg::CSR_ROW_COUNT, 15'(rows));
      write_csr(q4fed_pkg::CSR_HIDDEN_SIZE, 15'(hidden));
      loaded_rows.delete();
      loaded_groups.delete();
      start = issued_reqs;
      while (issued_reqs - start < budget) begin
         case ($urandom_range(0, 9))
            0: push_write($urandom_range(0, 20'hFFFFF), 8'($urandom));
            1, 2: begin
               n = $urandom_range(0, 4095);
               g = $urandom_range(0, 511);
               if ($urandom_range(0, 1)) n = $urandom_range(0, rows - 1);
               load_and_read(n, g, 1'b1);
            end
            3, 4: begin
               if (loaded_rows.size() != 0) begin
                  pick = $urandom_range(0, loaded_rows.size() - 1);
                  load_and_read(loaded_rows[pick], loaded_groups[pick], 1'b0);
               end else begin
                  load_and_read($urandom_range(0, rows - 1),
                                $urandom_range(0, hidden / 32 - 1), 1'b1);
               end
            end
            default: load_and_read($urandom_range(0, rows - 1),
                                   $urandom_range(0, hidden / 32 - 1), 1'b1);
         endcase
      end
      drain();
   endtask

   // request side
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            predict_request(req_payload);
            accepted_reqs++;
         end
         if (!req_valid || !req_stall) begin
            if (pending_reqs.size() != 0 && (calm || $urandom_range(0, 99) >= 25)) begin
               req_valid   <= 1'b1;
               req_payload <= pending_reqs.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // response side
   always @(posedge clock) begin
      q4fed_pkg::rsp_type e;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            seen_rsps++;
            if (expected_rsps.size() == 0) begin
               errors++;
               $display("unexpected response %p", rsp_payload);
            end else begin
               e = expected_rsps.pop_front();
               if (rsp_payload !== e) begin
                  errors++;
                  mismatches++;
                  if (mismatches <= 10)
                     $display({"mismatch: expected st=%0d idx=%0d val=%h last=%b,",
                               " got st=%0d idx=%0d val=%h last=%b"},
                              e.status, e.element_index, e.value_half, e.last,
                              rsp_payload.status, rsp_payload.element_index,
                              rsp_payload.value_half, rsp_payload.last);
               end
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (!hold_done && accepted_reqs >= 40) begin
            hold_done = 1'b1;
            hold_left = 400;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= !calm && ($urandom_range(0, 99) < 25);
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_CAP) begin
         $display("simulation failed");
         $finish;
      end
   end

   initial begin
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_payload   = '0;
      rsp_stall     = 1'b0;
      csr_wr_en     = 1'b0;
      csr_index     = '0;
      csr_data      = '0;
      rows_cfg      = '0;
      hidden_cfg    = '0;
      issued_reqs   = 0;
      accepted_reqs = 0;
      seen_rsps     = 0;
      group_reads   = 0;
      errors        = 0;
      mismatches    = 0;
      cycles        = 0;
      hold_left     = 0;
      hold_done     = 1'b0;
      calm          = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      #1;

      // registers still zero: shape error
      push_dequant(0, 0);
      push_dequant(4095, 511);
      drain();

      // smallest table
      write_csr(q4fed_pkg::CSR_ROW_COUNT, 15'd16);
      write_csr(q4fed_pkg::CSR_HIDDEN_SIZE, 15'd32);
      load_and_read(15, 0, 1'b1);
      push_dequant(16, 0);
      push_dequant(0, 1);
      drain();

      // largest legal shape does not fit memory
      write_csr(q4fed_pkg::CSR_ROW_COUNT, 15'd4096);
      write_csr(q4fed_pkg::CSR_HIDDEN_SIZE, 15'd16384);
      push_dequant(4095, 511);
      push_dequant(0, 0);
      drain();

      // register extremes and a row count off the 16 grid are bad shapes
      write_csr(q4fed_pkg::CSR_ROW_COUNT, 15'h1FFF);
      write_csr(q4fed_pkg::CSR_HIDDEN_SIZE, 15'h7FFF);
      push_dequant(0, 0);
      drain();
      write_csr(q4fed_pkg::CSR_ROW_COUNT, 15'd17);
      push_dequant(0, 0);
      drain();

      random_phase(64, 2048, 30);
      random_phase(80, 1056, 30);
      calm = 1'b1;
      random_phase(1024, 1024, 28);
      calm = 1'b0;
      random_phase(16, 16384, 25);
      random_phase(4096, 128, 25);

      $display("%0d requests, %0d full groups dequantized, %0d responses checked",
               accepted_reqs, group_reads, seen_rsps);
      $display("shapes from 16x32 to 4096x16384, including bad and oversized tables");
      if (errors == 0 && expected_rsps.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

`default_nettype wire
